### sv/smas_pkg.sv
// Shared types and constants for the sign majority agreement share unit.
`default_nettype none
package smas_pkg;

  localparam int PRICE_W = 32;
  localparam int FIELD_W = 17;
  localparam int DIV_STEPS = 17;
  localparam int STEP_W = 5;

  typedef logic [1:0] sign_t;
  localparam sign_t SIGN_FLAT = 2'b00;
  localparam sign_t SIGN_UP   = 2'b01;
  localparam sign_t SIGN_DOWN = 2'b11;

  typedef struct packed {
    logic neg;
    logic zero;
  } smas_flags_t;

endpackage
`default_nettype wire

### sv/sign_majority_agreement_share_unit.sv
// Top level of the sign majority agreement share unit.
// Takes one price beat at a time and is not ready again until that beat is
// finished. A beat whose price does not pair with a usable previous price
// passes through compare and finish only; a paired beat also scores, and once
// the sign window is full it first rotates the window through the tally logic
// one entry per cycle. A series_end beat adds restoring division (one quotient
// bit per cycle on the shared subtractor) and then a load of the result
// register; the division is skipped when nothing was scored. The load waits for
// as long as the previous report is still held unaccepted on the output. The
// result register holds a finished beat while the next series is already
// being taken in.
`default_nettype none
module sign_majority_agreement_share_unit
  import smas_pkg::*;
#(
  parameter int WINDOW = 5,
  parameter int SERIES_MAX = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [PRICE_W-1:0] in_price,
  input  wire logic                      in_price_missing,
  input  wire logic                      in_series_end,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [FIELD_W-1:0]             out_share,
  output logic                           out_share_valid,
  output logic [FIELD_W-1:0]             out_scored_count,
  output logic [FIELD_W-1:0]             out_hit_count
);

  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int CNT_W  = $clog2(SERIES_MAX + 1);
  localparam int UNIT_W = (CNT_W + 2 > PRICE_W + 1) ? CNT_W + 2 : PRICE_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_TALLY = 3'd2;
  localparam logic [2:0] ST_SCORE = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(SERIES_MAX);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

  logic [2:0]                state_r;
  logic signed [PRICE_W-1:0] price_r;
  logic                      usable_r;
  logic                      last_r;
  logic signed [PRICE_W-1:0] prev_price_r;
  logic                      prev_usable_r;
  sign_t                     sign_r;
  sign_t                     win_r [WINDOW];
  logic [FILL_W-1:0]         fill_r;
  logic [FILL_W-1:0]         tally_idx_r;
  logic [FILL_W-1:0]         pos_r;
  logic [FILL_W-1:0]         neg_r;
  logic [CNT_W-1:0]          scored_cnt_r;
  logic [CNT_W-1:0]          hit_cnt_r;
  logic [CNT_W-1:0]          rem_r;
  logic [FIELD_W-1:0]        quot_r;
  logic [STEP_W-1:0]         step_r;
  logic                      out_valid_r;
  logic [FIELD_W-1:0]        out_share_r;
  logic                      out_share_valid_r;
  logic [FIELD_W-1:0]        out_scored_r;
  logic [FIELD_W-1:0]        out_hit_r;

  logic [UNIT_W-1:0] unit_a;
  logic [UNIT_W-1:0] unit_b;
  logic [UNIT_W-1:0] unit_diff;
  smas_flags_t       unit_flags;
  logic [CNT_W:0]    trial;
  sign_t             maj;
  logic              out_free;

  // One subtractor serves both the price compare and the division steps.
  smas_sub #(.W(UNIT_W)) u_sub (
    .a     (unit_a),
    .b     (unit_b),
    .diff  (unit_diff),
    .flags (unit_flags)
  );

  always_comb begin
    trial = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
    if (state_r == ST_DIV) begin
      unit_a = UNIT_W'(trial);
      unit_b = UNIT_W'(scored_cnt_r);
    end else begin
      unit_a = UNIT_W'(signed'(price_r));
      unit_b = UNIT_W'(signed'(prev_price_r));
    end
    maj      = (pos_r > neg_r) ? SIGN_UP : SIGN_DOWN;
    out_free = !out_valid_r || out_ready;
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_price_r  <= '0;
      prev_usable_r <= 1'b0;
      fill_r        <= '0;
      scored_cnt_r  <= '0;
      hit_cnt_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      // Emit reloads the result register itself when the old beat leaves.
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            price_r  <= in_price;
            usable_r <= !in_price_missing && (in_price > 0);
            last_r   <= in_series_end;
            state_r  <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (unit_flags.zero) begin
            sign_r <= SIGN_FLAT;
          end else if (unit_flags.neg) begin
            sign_r <= SIGN_DOWN;
          end else begin
            sign_r <= SIGN_UP;
          end
          prev_price_r  <= price_r;
          prev_usable_r <= usable_r;
          pos_r         <= '0;
          neg_r         <= '0;
          tally_idx_r   <= '0;
          if (usable_r && prev_usable_r) begin
            state_r <= (fill_r == FILL_FULL) ? ST_TALLY : ST_SCORE;
          end else begin
            state_r <= ST_FIN;
          end
        end
        ST_TALLY: begin
          // Rotate the window so each entry passes position zero once.
          if (win_r[0] == SIGN_UP) begin
            pos_r <= pos_r + 1'b1;
          end else if (win_r[0] == SIGN_DOWN) begin
            neg_r <= neg_r + 1'b1;
          end
          for (int k = 0; k < WINDOW - 1; k++) begin
            win_r[k] <= win_r[k+1];
          end
          win_r[WINDOW-1] <= win_r[0];
          tally_idx_r     <= tally_idx_r + 1'b1;
          if (tally_idx_r == FILL_FULL - 1'b1) begin
            state_r <= ST_SCORE;
          end
        end
        ST_SCORE: begin
          if (pos_r != neg_r) begin
            if (scored_cnt_r < CNT_MAX) begin
              scored_cnt_r <= scored_cnt_r + 1'b1;
            end
            if ((sign_r == maj) && (hit_cnt_r < CNT_MAX)) begin
              hit_cnt_r <= hit_cnt_r + 1'b1;
            end
          end
          for (int k = 0; k < WINDOW - 1; k++) begin
            win_r[k] <= win_r[k+1];
          end
          win_r[WINDOW-1] <= sign_r;
          if (fill_r != FILL_FULL) begin
            fill_r <= fill_r + 1'b1;
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          rem_r  <= (hit_cnt_r > scored_cnt_r) ? scored_cnt_r : hit_cnt_r;
          quot_r <= '0;
          step_r <= '0;
          if (!last_r) begin
            state_r <= ST_IDLE;
          end else if (scored_cnt_r == '0) begin
            state_r <= ST_EMIT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          // Restoring division: one quotient bit per step.
          if (!unit_flags.neg) begin
            rem_r <= unit_diff[CNT_W-1:0];
          end else begin
            rem_r <= trial[CNT_W-1:0];
          end
          quot_r <= {quot_r[FIELD_W-2:0], !unit_flags.neg};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_LAST) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold until the result register is free, then clear series state.
          if (out_free) begin
            out_valid_r       <= 1'b1;
            out_share_r       <= quot_r;
            out_share_valid_r <= (scored_cnt_r != '0);
            out_scored_r      <= FIELD_W'(scored_cnt_r);
            out_hit_r         <= FIELD_W'(hit_cnt_r);
            prev_price_r      <= '0;
            prev_usable_r     <= 1'b0;
            fill_r            <= '0;
            scored_cnt_r      <= '0;
            hit_cnt_r         <= '0;
            state_r           <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_share        = out_share_r;
  assign out_share_valid  = out_share_valid_r;
  assign out_scored_count = out_scored_r;
  assign out_hit_count    = out_hit_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    hit_cnt_r <= scored_cnt_r)
    else $error("hit count exceeds scored count");

  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_FULL)
    else $error("window fill beyond window size");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_EMIT)
    else $error("result loaded outside emit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_share_valid_r) |-> (out_share_r == '0) && (out_scored_r == '0))
    else $error("invalid share with nonzero share or scored count");

endmodule
`default_nettype wire

### sv/smas_sub.sv
// Shared subtract and compare unit: difference plus sign and zero flags.
`default_nettype none
module smas_sub
  import smas_pkg::*;
#(
  parameter int W = 33
) (
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic [W-1:0]      diff,
  output smas_flags_t       flags
);

  always_comb begin
    diff       = a - b;
    flags.neg  = diff[W-1];
    flags.zero = (diff == '0);
  end

endmodule
`default_nettype wire

### verif/share_report_checker.sv
`timescale 1ns / 1ps
// Checker for the sign majority agreement share unit: predicts and compares series reports.
module share_report_checker
  import smas_pkg::*;
#(
  parameter int WINDOW = 5,
  parameter int SERIES_MAX = 65536
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic                      in_ready,
  input  wire logic signed [PRICE_W-1:0] in_price,
  input  wire logic                      in_price_missing,
  input  wire logic                      in_series_end,
  input  wire logic                      out_valid,
  input  wire logic                      out_ready,
  input  wire logic [FIELD_W-1:0]        out_share,
  input  wire logic                      out_share_valid,
  input  wire logic [FIELD_W-1:0]        out_scored_count,
  input  wire logic [FIELD_W-1:0]        out_hit_count,
  output int                             mismatch_count,
  output int                             reports_due
);

  typedef struct packed {
    logic [FIELD_W-1:0] share;
    logic               share_valid;
    logic [FIELD_W-1:0] scored;
    logic [FIELD_W-1:0] hit;
  } share_report_t;

  share_report_t             due_reports[$];
  logic signed [PRICE_W-1:0] prior_price;
  logic                      last_usable;
  sign_t                     recent_signs[WINDOW];
  int                        signs_held;
  int                        scored_total;
  int                        hit_total;

  task automatic clear_series();
    prior_price = '0;
    last_usable = 1'b0;
    signs_held = 0;
    scored_total = 0;
    hit_total = 0;
  endtask

  task automatic push_sign(input sign_t move);
    int    ups;
    int    downs;
    sign_t lead;
    ups = 0;
    downs = 0;
    // Score only against a full window with a strict majority.
    if (signs_held >= WINDOW) begin
      foreach (recent_signs[k]) begin
        if (recent_signs[k] == SIGN_UP) ups++;
        else if (recent_signs[k] == SIGN_DOWN) downs++;
      end
      if (ups != downs) begin
        lead = (ups > downs) ? SIGN_UP : SIGN_DOWN;
        if (scored_total < SERIES_MAX) scored_total++;
        if (move == lead && hit_total < SERIES_MAX) hit_total++;
      end
    end
    for (int k = 1; k < WINDOW; k++) recent_signs[k-1] = recent_signs[k];
    recent_signs[WINDOW-1] = move;
    if (signs_held < WINDOW) signs_held++;
  endtask

  task automatic take_price(input logic signed [PRICE_W-1:0] p, input logic miss,
                            input logic closes);
    logic          usable;
    share_report_t rep;
    longint        h;
    usable = !miss && (p > 0);
    if (usable && last_usable) begin
      push_sign((p > prior_price) ? SIGN_UP : ((p < prior_price) ? SIGN_DOWN : SIGN_FLAT));
    end
    prior_price = p;
    last_usable = usable;
    if (closes) begin
      rep = '0;
      if (scored_total > 0) begin
        h = (hit_total > scored_total) ? scored_total : hit_total;
        rep.share = FIELD_W'((h * longint'(65536)) / longint'(scored_total));
        rep.share_valid = 1'b1;
      end
      rep.scored = FIELD_W'(scored_total);
      rep.hit = FIELD_W'(hit_total);
      due_reports = {due_reports, rep};
      clear_series();
    end
  endtask

  always @(posedge clk) begin
    share_report_t got;
    share_report_t want;
    if (!rst_n) begin
      clear_series();
      due_reports.delete();
      mismatch_count = 0;
    end else begin
      // Retire the output beat first: a report never leaves on its own input beat.
      if (out_valid && out_ready) begin
        got = '{out_share, out_share_valid, out_scored_count, out_hit_count};
        if (due_reports.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected report share=%0d valid=%0d scored=%0d hit=%0d",
                     $realtime, got.share, got.share_valid, got.scored, got.hit);
          mismatch_count++;
        end else begin
          want = due_reports.pop_front();
          if (got.share !== want.share || got.share_valid !== want.share_valid ||
              got.scored !== want.scored || got.hit !== want.hit) begin
            if (mismatch_count < 10)
              $display({"%0t: report mismatch expected share=%0d valid=%0d scored=%0d ",
                        "hit=%0d actual share=%0d valid=%0d scored=%0d hit=%0d"},
                       $realtime, want.share, want.share_valid, want.scored, want.hit,
                       got.share, got.share_valid, got.scored, got.hit);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) take_price(in_price, in_price_missing, in_series_end);
    end
    reports_due = due_reports.size();
  end

endmodule

### verif/sign_majority_agreement_share_unit_test.sv
`timescale 1ns / 1ps
// Testbench top for the sign majority agreement share unit: stimulus and verdict.
module sign_majority_agreement_share_unit_test
  import smas_pkg::*;
();

  localparam int WINDOW = 5;
  localparam int SERIES_MAX = 65536;
  localparam int PRICE_BEATS = 1860;
  localparam int DRAIN_CYCLES = 40;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [PRICE_W-1:0] in_price;
  logic                      in_price_missing;
  logic                      in_series_end;
  logic                      out_valid;
  logic                      out_ready;
  logic [FIELD_W-1:0]        out_share;
  logic                      out_share_valid;
  logic [FIELD_W-1:0]        out_scored_count;
  logic [FIELD_W-1:0]        out_hit_count;
  int                        mismatch_count;
  int                        reports_due;
  bit                        in_gaps_on = 1'b1;

  always #6 clk = ~clk;

  sign_majority_agreement_share_unit #(
    .WINDOW(WINDOW),
    .SERIES_MAX(SERIES_MAX)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_price(in_price),
    .in_price_missing(in_price_missing),
    .in_series_end(in_series_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_share(out_share),
    .out_share_valid(out_share_valid),
    .out_scored_count(out_scored_count),
    .out_hit_count(out_hit_count)
  );

  share_report_checker #(
    .WINDOW(WINDOW),
    .SERIES_MAX(SERIES_MAX)
  ) i_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_price(in_price),
    .in_price_missing(in_price_missing),
    .in_series_end(in_series_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_share(out_share),
    .out_share_valid(out_share_valid),
    .out_scored_count(out_scored_count),
    .out_hit_count(out_hit_count),
    .mismatch_count(mismatch_count),
    .reports_due(reports_due)
  );

  function automatic int draw_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_beat(input logic signed [PRICE_W-1:0] p, input logic miss,
                           input logic closes);
    int gap;
    gap = in_gaps_on ? draw_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_price <= p;
    in_price_missing <= miss;
    in_series_end <= closes;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly a price walk with a trend, so full windows and majorities occur;
  // some series are pure noise over the whole field range.
  task automatic send_random_series(output int beats);
    int                        len;
    int                        pick;
    int                        trend;
    longint                    walk;
    longint                    nxt;
    logic signed [PRICE_W-1:0] p;
    logic                      miss;
    bit                        noisy;
    pick = $urandom_range(0, 99);
    if (pick < 10) len = $urandom_range(1, 4);
    else if (pick < 90) len = $urandom_range(5, 40);
    else len = $urandom_range(60, 150);
    noisy = ($urandom_range(0, 9) == 0);
    in_gaps_on = ($urandom_range(0, 3) != 0);
    walk = $urandom_range(0, 1) ? longint'($urandom_range(1, 30))
                                : longint'($urandom_range(1, 32'h7fff_ffff));
    trend = int'($urandom_range(0, 2)) - 1;
    for (int n = 0; n < len; n++) begin
      pick = $urandom_range(0, 99);
      if (noisy || pick < 3) begin
        p = $urandom;
        miss = $urandom_range(0, 1);
      end else if (pick < 8) begin
        p = $urandom;
        miss = 1'b1;
      end else begin
        nxt = walk + trend + int'($urandom_range(0, 4)) - 2;
        // Reflect off the usable range.
        if (nxt < 1 || nxt > 64'sh7fff_ffff) nxt = walk - (nxt - walk);
        walk = nxt;
        p = walk[PRICE_W-1:0];
        miss = 1'b0;
      end
      send_beat(p, miss, n == len - 1);
    end
    beats = len;
  endtask

  // Receiver: ready runs, stalls mostly short, a few long, and some long clean stretches.
  initial begin
    int run;
    int pick;
    bit level;
    out_ready = 1'b0;
    level = 1'b0;
    forever begin
      level = !level;
      pick = $urandom_range(0, 99);
      if (level) run = (pick < 10) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      else run = (pick < 85) ? $urandom_range(1, 3) : $urandom_range(15, 60);
      repeat (run) begin
        @(negedge clk);
        out_ready <= level;
      end
    end
  end

  initial begin
    int beats_sent;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_price = '0;
    in_price_missing = 1'b0;
    in_series_end = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Lone missing beat that closes its series: nothing scored.
    send_beat(32'sh7fff_ffff, 1'b1, 1'b1);
    // Field extremes, skipped pairs, hits, misses and tied windows.
    send_beat(32'sh7fff_ffff, 1'b0, 1'b0);
    send_beat(-32'sh8000_0000, 1'b0, 1'b0);
    send_beat(0, 1'b0, 1'b0);
    send_beat(1, 1'b0, 1'b0);
    send_beat(2, 1'b0, 1'b0);
    send_beat(2, 1'b0, 1'b0);
    send_beat(1, 1'b0, 1'b0);
    send_beat(5, 1'b0, 1'b0);
    send_beat(6, 1'b0, 1'b0);
    send_beat(7, 1'b0, 1'b0);
    send_beat(3, 1'b0, 1'b0);
    send_beat(9, 1'b1, 1'b0);
    send_beat(4, 1'b0, 1'b0);
    send_beat(4, 1'b0, 1'b0);
    send_beat(3, 1'b0, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0, 1'b0);
    send_beat(32'sh7fff_ffff, 1'b0, 1'b1);
    // All-flat window, then one move: never scored.
    for (n = 0; n < 7; n++) send_beat(5, 1'b0, 1'b0);
    send_beat(6, 1'b0, 1'b1);

    beats_sent = 0;
    while (beats_sent < PRICE_BEATS) begin
      send_random_series(n);
      beats_sent += n;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (reports_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Hard stop, several times the slowest legal run.
  initial begin
    #50_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/smas_pkg.sv
sv/smas_sub.sv
sv/sign_majority_agreement_share_unit.sv
verif/share_report_checker.sv
verif/sign_majority_agreement_share_unit_test.sv
